@@ hw/rtl/rmn_pkg.sv @@
// Roman numeral encoder: shared types and constants.
// Holds the queued request format and the ASCII codes of the numeral letters.
// No dependencies.
package rmn_pkg;

  // ASCII codes of the numeral letters
  localparam logic [6:0] SYM_I    = 7'h49;
  localparam logic [6:0] SYM_V    = 7'h56;
  localparam logic [6:0] SYM_X    = 7'h58;
  localparam logic [6:0] SYM_L    = 7'h4C;
  localparam logic [6:0] SYM_C    = 7'h43;
  localparam logic [6:0] SYM_D    = 7'h44;
  localparam logic [6:0] SYM_M    = 7'h4D;
  localparam logic [6:0] SYM_NONE = 7'h00;

  // Decimal digit places, most significant first
  localparam logic [1:0] POS_THOU = 2'd0;
  localparam logic [1:0] POS_HUND = 2'd1;
  localparam logic [1:0] POS_TENS = 2'd2;
  localparam logic [1:0] POS_ONES = 2'd3;

  // Classified request: error flag and decimal digits indexed by place
  typedef struct packed {
    logic            err;
    logic [3:0][3:0] dig;
  } rmn_item_t;

endpackage

@@ hw/rtl/rmn_in_if.sv @@
// Input channel of the Roman numeral encoder: valid/ready plus the value.
// No dependencies.
interface rmn_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

@@ hw/rtl/rmn_out_if.sv @@
// Result channel of the Roman numeral encoder: one character per transfer, last ends a request.
// No dependencies.
interface rmn_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] symbol;
  logic       last;
  logic       error;

  modport source (output valid, output symbol, output last, output error, input ready);
  modport sink   (input valid, input symbol, input last, input error, output ready);
endinterface

@@ hw/rtl/integer_to_roman_encoder.sv @@
// Integer to Roman numeral encoder, top level.
// Throughput: one character per cycle unless the output stalls. A numeral
// has 1 to 15 characters and an out-of-range value gives one error character;
// the back-end sequencer takes the next value as the last character goes out.
// Reset (synchronous, active low) clears valid flags, queue counts and sequencer.
module integer_to_roman_encoder
  import rmn_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  rmn_in_if.sink    in_chan,
  rmn_out_if.source out_chan
);

  logic      fq_valid;
  logic      fq_ready;
  rmn_item_t fq_item;
  logic      q_valid;
  logic      q_ready;
  rmn_item_t q_item;

  // Range check and digit split
  rmn_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .in_value (in_chan.value),
    .fq_valid (fq_valid),
    .fq_ready (fq_ready),
    .fq_item  (fq_item)
  );

  // Decoupling queue
  rmn_queue #(.Depth(QueueDepth)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_item  (fq_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  // Character sequencer
  rmn_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_symbol (out_chan.symbol),
    .out_last   (out_chan.last),
    .out_error  (out_chan.error)
  );

  // An error request is a single closing character with no letter
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.error |-> out_chan.last && out_chan.symbol == SYM_NONE)
    else $error("error request not a lone closing character");

  // A normal character is always a numeral letter
  a_letter: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.error |->
      out_chan.symbol == SYM_I || out_chan.symbol == SYM_V || out_chan.symbol == SYM_X ||
      out_chan.symbol == SYM_L || out_chan.symbol == SYM_C || out_chan.symbol == SYM_D ||
      out_chan.symbol == SYM_M)
    else $error("character outside the numeral alphabet");

  // A request stalled at the queue input keeps its digits
  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fq_valid && !fq_ready |=> fq_valid && $stable(fq_item))
    else $error("front end dropped or altered a stalled request");

endmodule

@@ hw/rtl/rmn_front.sv @@
// Front end: registers the value, checks its range and splits it into
// decimal digits over two pipeline stages. Uses rmn_pkg.
module rmn_front
  import rmn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [11:0] in_value,
  output logic        fq_valid,
  input  logic        fq_ready,
  output rmn_item_t   fq_item
);

  localparam logic [11:0] MaxValue = 12'd3999;
  localparam logic [5:0]  Recip100 = 6'd41;   // 41/4096 ~ 1/100 for x < 1000
  localparam logic [6:0]  Recip10  = 7'd103;  // 103/1024 ~ 1/10 for x < 100

  logic        s1_valid_r;
  logic [11:0] value_r;
  logic        s2_valid_r;
  logic        s2_err_r;
  logic [3:0]  s2_thou_r;
  logic [3:0]  s2_hund_r;
  logic [6:0]  s2_rem_r;

  logic        s1_free;
  logic        s2_free;
  logic        s1_err;
  logic [1:0]  s1_thou;
  logic [11:0] s1_rem1;
  logic [15:0] s1_hprod;
  logic [3:0]  s1_hund;
  logic [6:0]  s1_rem2;
  logic [13:0] s2_tprod;
  logic [3:0]  s2_tens;
  logic [3:0]  s2_ones;

  assign s2_free  = !s2_valid_r || fq_ready;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_ready = s1_free;

  // Stage 1: range check, thousands by compare, hundreds by reciprocal
  always_comb begin
    s1_err = (value_r == 12'd0) || (value_r > MaxValue);
    if (value_r >= 12'd3000) begin
      s1_thou = 2'd3;
    end else if (value_r >= 12'd2000) begin
      s1_thou = 2'd2;
    end else if (value_r >= 12'd1000) begin
      s1_thou = 2'd1;
    end else begin
      s1_thou = 2'd0;
    end
    s1_rem1  = value_r - 12'(s1_thou * 12'd1000);
    s1_hprod = 16'(s1_rem1[9:0]) * 16'(Recip100);
    s1_hund  = s1_hprod[15:12];
    s1_rem2  = 7'(s1_rem1 - 12'(s1_hund * 12'd100));
  end

  // Stage 2: tens by reciprocal, ones by subtraction
  always_comb begin
    s2_tprod = 14'(s2_rem_r) * 14'(Recip10);
    s2_tens  = s2_tprod[13:10];
    s2_ones  = 4'(s2_rem_r - 7'(s2_tens * 7'd10));
  end

  assign fq_valid            = s2_valid_r;
  assign fq_item.err         = s2_err_r;
  assign fq_item.dig[POS_THOU] = s2_thou_r;
  assign fq_item.dig[POS_HUND] = s2_hund_r;
  assign fq_item.dig[POS_TENS] = s2_tens;
  assign fq_item.dig[POS_ONES] = s2_ones;

  // Pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_free) s1_valid_r <= in_valid;
      if (s2_free) s2_valid_r <= s1_valid_r;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (s1_free && in_valid) value_r <= in_value;
    if (s2_free && s1_valid_r) begin
      s2_err_r  <= s1_err;
      s2_thou_r <= {2'b00, s1_thou};
      s2_hund_r <= s1_hund;
      s2_rem_r  <= s1_rem2;
    end
  end

endmodule

@@ hw/rtl/rmn_queue.sv @@
// Short request queue between front end and back end.
// Register-based FIFO of rmn_item_t. Uses rmn_pkg.
module rmn_queue
  import rmn_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  rmn_item_t wr_item,
  output logic      rd_valid,
  input  logic      rd_ready,
  output rmn_item_t rd_item
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  rmn_item_t       mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r;
  logic [PtrW-1:0] rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            push;
  logic            pop;

  assign wr_ready = (count_r != Full);
  assign rd_valid = (count_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_item;
  end

endmodule

@@ hw/rtl/rmn_back.sv @@
// Back end: walks the digits of one request and emits one numeral character
// per cycle, unless the output stalls, into a registered output. Uses rmn_pkg.
module rmn_back
  import rmn_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  output logic      q_ready,
  input  rmn_item_t q_item,
  output logic      out_valid,
  input  logic      out_ready,
  output logic [6:0] out_symbol,
  output logic      out_last,
  output logic      out_error
);

  // Characters needed for one decimal digit
  function automatic logic [2:0] dig_len(input logic [3:0] d);
    logic [2:0] n;
    case (d)
      4'd1, 4'd5:             n = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9: n = 3'd2;
      4'd3, 4'd7:             n = 3'd3;
      4'd8:                   n = 3'd4;
      default:                n = 3'd0;
    endcase
    return n;
  endfunction

  // Lowest set place in a mask of nonzero digits
  function automatic logic [1:0] low_place(input logic [3:0] m);
    logic [1:0] p;
    p = POS_ONES;
    for (int i = 3; i >= 0; i--) begin
      if (m[i]) p = 2'(i);
    end
    return p;
  endfunction

  rmn_item_t  item_r;
  logic       busy_r;
  logic [1:0] pos_r;
  logic [1:0] k_r;
  logic       out_valid_r;
  logic [6:0] out_symbol_r;
  logic       out_last_r;
  logic       out_error_r;

  logic [3:0] cur_dig;
  logic [2:0] cur_len;
  logic [3:0] nz;
  logic [3:0] nz_above;
  logic [3:0] nz_new;
  logic       fin_digit;
  logic       more;
  logic       out_free;
  logic       emit;
  logic       item_done;
  logic       pop;
  logic [6:0] sym_one;
  logic [6:0] sym_five;
  logic [6:0] sym_ten;
  logic [6:0] sym;

  assign cur_dig   = item_r.dig[pos_r];
  assign cur_len   = dig_len(cur_dig);
  assign fin_digit = ((3'(k_r) + 3'd1) == cur_len);

  // Nonzero digit places, and those after the current one
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      nz[i]     = (item_r.dig[i] != 4'd0);
      nz_new[i] = (q_item.dig[i] != 4'd0);
      nz_above[i] = nz[i] && (2'(i) > pos_r);
    end
  end
  assign more = (nz_above != 4'd0);

  // Letters for the current place
  always_comb begin
    case (pos_r)
      POS_THOU: begin
        sym_one = SYM_M; sym_five = SYM_NONE; sym_ten = SYM_NONE;
      end
      POS_HUND: begin
        sym_one = SYM_C; sym_five = SYM_D; sym_ten = SYM_M;
      end
      POS_TENS: begin
        sym_one = SYM_X; sym_five = SYM_L; sym_ten = SYM_C;
      end
      default: begin
        sym_one = SYM_I; sym_five = SYM_V; sym_ten = SYM_X;
      end
    endcase
  end

  // Character k of the current digit
  always_comb begin
    if (item_r.err) begin
      sym = SYM_NONE;
    end else if (cur_dig == 4'd9) begin
      sym = (k_r == 2'd0) ? sym_one : sym_ten;
    end else if (cur_dig == 4'd4) begin
      sym = (k_r == 2'd0) ? sym_one : sym_five;
    end else if (cur_dig >= 4'd5) begin
      sym = (k_r == 2'd0) ? sym_five : sym_one;
    end else begin
      sym = sym_one;
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign emit      = busy_r && out_free;
  assign item_done = emit && (item_r.err || (fin_digit && !more));
  assign pop       = q_valid && (!busy_r || item_done);
  assign q_ready   = !busy_r || item_done;

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= POS_THOU;
      k_r         <= 2'd0;
    end else begin
      if (out_free) out_valid_r <= emit;
      if (pop) begin
        busy_r <= 1'b1;
        pos_r  <= low_place(nz_new);
        k_r    <= 2'd0;
      end else if (item_done) begin
        busy_r <= 1'b0;
      end else if (emit) begin
        if (fin_digit) begin
          pos_r <= low_place(nz_above);
          k_r   <= 2'd0;
        end else begin
          k_r <= k_r + 2'd1;
        end
      end
    end
  end

  // Request and output payload
  always_ff @(posedge clk) begin
    if (pop) item_r <= q_item;
    if (emit) begin
      out_symbol_r <= sym;
      out_last_r   <= item_done;
      out_error_r  <= item_r.err;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_last   = out_last_r;
  assign out_error  = out_error_r;

endmodule
